@@ src/imm_pkg.sv @@
// shared types and constants for the integer matrix multiplier
`default_nettype none

package imm_pkg;

  localparam int unsigned DimDefault = 8;
  localparam int unsigned ElemW      = 16;
  localparam int unsigned ProdW      = 32;
  localparam int unsigned AccW       = 35;
  localparam int unsigned ColW       = 3;

  localparam logic OpLoadB = 1'b0;
  localparam logic OpElemA = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MAC,
    ST_EMIT
  } imm_state_e;

  typedef struct packed {
    logic a_load;
    logic acc_add;
    logic acc_drain;
  } imm_dp_ctrl_t;

endpackage

`default_nettype wire

@@ src/integer_matrix_multiply.sv @@
// integer matrix multiplier top level: res = A x B, DIM by DIM
//
// input channel (in_valid_i / in_stall_o): each request carries operation_i
// and element_value_i. operation 0 writes the next element of B in row-major
// order, wrapping after the last one; operation 1 supplies the next element of
// A, row by row. output channel (out_valid_o / out_stall_i): after the last
// A element of a row, the DIM sums of that row come out in column order, with
// row_last_o set on the final one.
// an A element runs DIM multiply-accumulates on the one shared multiplier
// against one row of B read from the store, one column per cycle; no new
// request is taken until the pass ends. at a row end the DIM sums are emitted
// before the next request is taken.
// after reset every entry of the B store (DEPTH = DIM*DIM) is swept to zero
// with in_stall_o high; the accumulators reset to zero.
// while the receiver stalls, the head result holds and no request is taken.
`default_nettype none

module integer_matrix_multiply #(
  parameter int unsigned DIM = imm_pkg::DimDefault
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic                              operation_i,
  input  wire logic signed [imm_pkg::ElemW-1:0]  element_value_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic signed      [imm_pkg::AccW-1:0]   product_value_o,
  output logic             [imm_pkg::ColW-1:0]   column_index_o,
  output logic                                   row_last_o
);

  localparam int unsigned DEPTH = DIM * DIM;
  localparam int unsigned AW    = $clog2(DEPTH);

  imm_pkg::imm_dp_ctrl_t            dp_ctrl;
  logic                             ram_we;
  logic [AW-1:0]                    ram_waddr;
  logic                             ram_wzero;
  logic [AW-1:0]                    ram_raddr;
  logic [imm_pkg::ElemW-1:0]        ram_wdata;
  logic [imm_pkg::ElemW-1:0]        ram_rdata;

  assign ram_wdata = ram_wzero ? '0 : element_value_i;

  imm_ctrl #(
    .DIM(DIM)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .column_index_o (column_index_o),
    .row_last_o     (row_last_o),
    .ram_we_o       (ram_we),
    .ram_waddr_o    (ram_waddr),
    .ram_wzero_o    (ram_wzero),
    .ram_raddr_o    (ram_raddr),
    .dp_ctrl_o      (dp_ctrl)
  );

  imm_ram #(
    .WIDTH(imm_pkg::ElemW),
    .DEPTH(DEPTH)
  ) u_b_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  imm_datapath #(
    .DIM(DIM)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (dp_ctrl),
    .elem_i          (element_value_i),
    .b_elem_i        ($signed(ram_rdata)),
    .product_value_o (product_value_o)
  );

endmodule

`default_nettype wire

@@ src/imm_ram.sv @@
// generic single write port ram with registered read
`default_nettype none

module imm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ src/imm_datapath.sv @@
// shared multiplier, product register and rotating row accumulator line
`default_nettype none

module imm_datapath #(
  parameter int unsigned DIM = imm_pkg::DimDefault
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire imm_pkg::imm_dp_ctrl_t             ctrl_i,
  input  wire logic signed [imm_pkg::ElemW-1:0]  elem_i,
  input  wire logic signed [imm_pkg::ElemW-1:0]  b_elem_i,
  output logic signed      [imm_pkg::AccW-1:0]   product_value_o
);

  logic signed [imm_pkg::ElemW-1:0] a_q;
  logic signed [imm_pkg::ProdW-1:0] prod_q;
  logic signed [imm_pkg::AccW-1:0]  acc_q [DIM];
  logic signed [imm_pkg::AccW-1:0]  tail_d;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.a_load) begin
      a_q <= elem_i;
    end
    prod_q <= a_q * b_elem_i;
  end

  always_comb begin
    if (ctrl_i.acc_add) begin
      tail_d = acc_q[0] + imm_pkg::AccW'(prod_q);
    end else begin
      tail_d = '0;
    end
  end

  // head is consumed, tail takes the new sum or zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DIM; i++) begin
        acc_q[i] <= '0;
      end
    end else if (ctrl_i.acc_add || ctrl_i.acc_drain) begin
      for (int i = 0; i < DIM - 1; i++) begin
        acc_q[i] <= acc_q[i+1];
      end
      acc_q[DIM-1] <= tail_d;
    end
  end

  assign product_value_o = acc_q[0];

endmodule

`default_nettype wire

@@ src/imm_ctrl.sv @@
// sequencer: store clearing, b loads, mac passes and row emission
`default_nettype none

module imm_ctrl #(
  parameter int unsigned DIM = imm_pkg::DimDefault,
  localparam int unsigned DEPTH = DIM * DIM,
  localparam int unsigned AW    = $clog2(DEPTH),
  localparam int unsigned CW    = $clog2(DIM)
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic                        operation_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [imm_pkg::ColW-1:0]         column_index_o,
  output logic                             row_last_o,
  output logic                             ram_we_o,
  output logic [AW-1:0]                    ram_waddr_o,
  output logic                             ram_wzero_o,
  output logic [AW-1:0]                    ram_raddr_o,
  output imm_pkg::imm_dp_ctrl_t            dp_ctrl_o
);

  imm_pkg::imm_state_e state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [AW-1:0] load_pos_q, load_pos_d;
  logic [AW-1:0] base_q, base_d;
  logic [CW-1:0] k_q, k_d;
  logic [CW-1:0] iss_q, iss_d;
  logic          iss_act_q, iss_act_d;
  logic          rd_v_q, rd_v_d;
  logic          prod_v_q, prod_v_d;
  logic [CW-1:0] mac_q, mac_d;
  logic [CW-1:0] emit_q, emit_d;
  logic          in_acc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= imm_pkg::ST_CLEAR;
      clr_q      <= '0;
      load_pos_q <= '0;
      base_q     <= '0;
      k_q        <= '0;
      iss_q      <= '0;
      iss_act_q  <= 1'b0;
      rd_v_q     <= 1'b0;
      prod_v_q   <= 1'b0;
      mac_q      <= '0;
      emit_q     <= '0;
    end else begin
      state_q    <= state_d;
      clr_q      <= clr_d;
      load_pos_q <= load_pos_d;
      base_q     <= base_d;
      k_q        <= k_d;
      iss_q      <= iss_d;
      iss_act_q  <= iss_act_d;
      rd_v_q     <= rd_v_d;
      prod_v_q   <= prod_v_d;
      mac_q      <= mac_d;
      emit_q     <= emit_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    load_pos_d = load_pos_q;
    base_d     = base_q;
    k_d        = k_q;
    iss_d      = iss_q;
    iss_act_d  = iss_act_q;
    rd_v_d     = 1'b0;
    prod_v_d   = rd_v_q;
    mac_d      = mac_q;
    emit_d     = emit_q;

    in_stall_o     = (state_q != imm_pkg::ST_IDLE);
    in_acc         = in_valid_i && !in_stall_o;
    out_valid_o    = 1'b0;
    column_index_o = imm_pkg::ColW'(emit_q);
    row_last_o     = (emit_q == CW'(DIM - 1));
    ram_we_o       = 1'b0;
    ram_waddr_o    = load_pos_q;
    ram_wzero_o    = 1'b0;
    ram_raddr_o    = base_q + AW'(iss_q);
    dp_ctrl_o      = '0;

    case (state_q)
      imm_pkg::ST_CLEAR: begin
        ram_we_o    = 1'b1;
        ram_wzero_o = 1'b1;
        ram_waddr_o = clr_q;
        clr_d       = clr_q + AW'(1);
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = imm_pkg::ST_IDLE;
        end
      end
      imm_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (operation_i == imm_pkg::OpLoadB) begin
            ram_we_o = 1'b1;
            if (load_pos_q == AW'(DEPTH - 1)) begin
              load_pos_d = '0;
            end else begin
              load_pos_d = load_pos_q + AW'(1);
            end
          end else begin
            dp_ctrl_o.a_load = 1'b1;
            iss_d            = '0;
            iss_act_d        = 1'b1;
            mac_d            = '0;
            state_d          = imm_pkg::ST_MAC;
          end
        end
      end
      imm_pkg::ST_MAC: begin
        rd_v_d = iss_act_q;
        if (iss_act_q) begin
          iss_d = iss_q + CW'(1);
          if (iss_q == CW'(DIM - 1)) begin
            iss_act_d = 1'b0;
          end
        end
        if (prod_v_q) begin
          dp_ctrl_o.acc_add = 1'b1;
          mac_d             = mac_q + CW'(1);
          if (mac_q == CW'(DIM - 1)) begin
            if (k_q == CW'(DIM - 1)) begin
              k_d     = '0;
              base_d  = '0;
              emit_d  = '0;
              state_d = imm_pkg::ST_EMIT;
            end else begin
              k_d     = k_q + CW'(1);
              base_d  = base_q + AW'(DIM);
              state_d = imm_pkg::ST_IDLE;
            end
          end
        end
      end
      imm_pkg::ST_EMIT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          dp_ctrl_o.acc_drain = 1'b1;
          emit_d              = emit_q + CW'(1);
          if (emit_q == CW'(DIM - 1)) begin
            state_d = imm_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = imm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ tb/integer_matrix_multiply_tb.sv @@
// self-checking testbench for the integer matrix multiplier, with a row product scoreboard
`timescale 1ns / 1ps

typedef struct {
  logic signed [imm_pkg::AccW-1:0] value;
  logic        [imm_pkg::ColW-1:0] col;
  logic                            last;
} row_sum_t;

class product_tracker;
  logic signed [imm_pkg::ElemW-1:0] b_store [imm_pkg::DimDefault*imm_pkg::DimDefault];
  logic signed [imm_pkg::AccW-1:0]  acc [imm_pkg::DimDefault];
  int unsigned                      load_ptr;
  int unsigned                      inner_ptr;
  row_sum_t                         pending_sums [$];
  int unsigned                      mismatches;
  int unsigned                      results_checked;
  int unsigned                      rows_checked;
  int unsigned                      loads;
  int unsigned                      a_elems;

  function new();
    foreach (b_store[i]) b_store[i] = '0;
    foreach (acc[i]) acc[i] = '0;
    load_ptr        = 0;
    inner_ptr       = 0;
    mismatches      = 0;
    results_checked = 0;
    rows_checked    = 0;
    loads           = 0;
    a_elems         = 0;
  endfunction

  function int unsigned outstanding();
    return pending_sums.size();
  endfunction

  function void note_request(logic op, logic signed [imm_pkg::ElemW-1:0] val);
    row_sum_t                        sum;
    logic signed [imm_pkg::AccW-1:0] prod;
    int unsigned                     j;
    if (op == imm_pkg::OpLoadB) begin
      b_store[load_ptr] = val;
      load_ptr = (load_ptr + 1) % (imm_pkg::DimDefault * imm_pkg::DimDefault);
      loads++;
      return;
    end
    a_elems++;
    for (j = 0; j < imm_pkg::DimDefault; j++) begin
      prod   = val * b_store[inner_ptr * imm_pkg::DimDefault + j];
      acc[j] = acc[j] + prod;
    end
    inner_ptr++;
    if (inner_ptr == imm_pkg::DimDefault) begin
      for (j = 0; j < imm_pkg::DimDefault; j++) begin
        sum.value = acc[j];
        sum.col   = j[imm_pkg::ColW-1:0];
        sum.last  = (j == imm_pkg::DimDefault - 1);
        pending_sums.push_back(sum);
        acc[j] = '0;
      end
      inner_ptr = 0;
    end
  endfunction

  function void check_result(logic signed [imm_pkg::AccW-1:0] value,
                             logic [imm_pkg::ColW-1:0] col, logic last);
    row_sum_t want;
    if (pending_sums.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: value=%0d col=%0d last=%0b", value, col, last);
      return;
    end
    want = pending_sums.pop_front();
    results_checked++;
    if (want.last) rows_checked++;
    if (want.value !== value || want.col !== col || want.last !== last) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: expected value=%0d col=%0d last=%0b, got value=%0d col=%0d last=%0b",
                 want.value, want.col, want.last, value, col, last);
    end
  endfunction
endclass

module integer_matrix_multiply_tb;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned RandomItems = 270;

  logic                             clk_i           = 1'b0;
  logic                             rst_ni          = 1'b0;
  logic                             in_valid_i      = 1'b0;
  logic                             operation_i     = imm_pkg::OpLoadB;
  logic signed [imm_pkg::ElemW-1:0] element_value_i = '0;
  logic                             out_stall_i     = 1'b0;
  logic                             in_stall_o;
  logic                             out_valid_o;
  logic signed [imm_pkg::AccW-1:0]  product_value_o;
  logic        [imm_pkg::ColW-1:0]  column_index_o;
  logic                             row_last_o;

  product_tracker board;
  bit             calm_mode  = 1'b0;
  int unsigned    items_sent = 0;

  integer_matrix_multiply dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .operation_i     (operation_i),
    .element_value_i (element_value_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .product_value_o (product_value_o),
    .column_index_o  (column_index_o),
    .row_last_o      (row_last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned draw_gap();
    return calm_mode ? 0 : $urandom_range(0, 11);
  endfunction

  function automatic logic signed [imm_pkg::ElemW-1:0] pick_element();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 9))
      0:       return -16'sd32768;
      1:       return 16'sd32767;
      2:       return '0;
      3:       return -16'sd1;
      default: return r[imm_pkg::ElemW-1:0];
    endcase
  endfunction

  task automatic send_request(input logic op, input logic signed [imm_pkg::ElemW-1:0] val);
    int unsigned gap;
    gap = draw_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    operation_i     <= op;
    element_value_i <= val;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    board.note_request(op, val);
    items_sent++;
  endtask

  task automatic load_random_b(input int unsigned count);
    repeat (count) send_request(imm_pkg::OpLoadB, pick_element());
  endtask

  // one A row, sometimes with a B load slipped in mid-row
  task automatic send_a_row();
    int unsigned split;
    int unsigned k;
    split = ($urandom_range(0, 5) == 0) ? $urandom_range(1, imm_pkg::DimDefault - 1)
                                        : imm_pkg::DimDefault;
    for (k = 0; k < imm_pkg::DimDefault; k++) begin
      if (k == split) send_request(imm_pkg::OpLoadB, pick_element());
      send_request(imm_pkg::OpElemA, pick_element());
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (board.outstanding() != 0);
  endtask

  initial begin
    logic signed [imm_pkg::ElemW-1:0] extreme_row [imm_pkg::DimDefault] =
      '{16'sd32767, -16'sd32768, 16'sd0, -16'sd1, 16'sd1, 16'sd32767, -16'sd32768, 16'sd12345};
    logic signed [imm_pkg::ElemW-1:0] b_row [imm_pkg::DimDefault] =
      '{16'sd32767, -16'sd32768, -16'sd1, 16'sd1, 16'sd0, 16'sd32767, -16'sd32768, 16'sd21845};
    int unsigned base;
    bit          extremes_done;
    int unsigned i;
    board = new();
    extremes_done = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // row against an all-zero store
    foreach (extreme_row[n]) send_request(imm_pkg::OpElemA, extreme_row[n]);
    // first row of B with extremes, then a row with a load in the middle
    foreach (b_row[n]) send_request(imm_pkg::OpLoadB, b_row[n]);
    send_request(imm_pkg::OpElemA, -16'sd32768);
    send_request(imm_pkg::OpLoadB, -16'sd32768);
    for (i = 1; i < imm_pkg::DimDefault; i++) send_request(imm_pkg::OpElemA, extreme_row[i]);
    wait_drained();

    base = items_sent;
    load_random_b(imm_pkg::DimDefault * imm_pkg::DimDefault);
    while (items_sent < base + RandomItems) begin
      if (!extremes_done && items_sent >= base + 120) begin
        // largest and smallest sums: whole store at the negative extreme
        extremes_done = 1'b1;
        repeat (imm_pkg::DimDefault * imm_pkg::DimDefault)
          send_request(imm_pkg::OpLoadB, -16'sd32768);
        while (board.inner_ptr != 0) send_request(imm_pkg::OpElemA, -16'sd32768);
        repeat (imm_pkg::DimDefault) send_request(imm_pkg::OpElemA, -16'sd32768);
        repeat (imm_pkg::DimDefault) send_request(imm_pkg::OpElemA, 16'sd32767);
      end
      case ($urandom_range(0, 9))
        5, 6: load_random_b($urandom_range(1, 12));
        7: repeat ($urandom_range(1, 4)) send_request(1'($urandom), pick_element());
        9: begin
          wait_drained();
          calm_mode = ~calm_mode;
        end
        default: send_a_row();
      endcase
    end
    wait_drained();
    repeat (3 * imm_pkg::DimDefault + 8) @(posedge clk_i);

    $display("ran %0d requests: %0d B loads, %0d A elements",
             items_sent, board.loads, board.a_elems);
    $display("checked %0d results in %0d rows, %0d mismatches",
             board.results_checked, board.rows_checked, board.mismatches);
    if (board.mismatches == 0 && board.outstanding() == 0) begin
      $display("integer_matrix_multiply verification clean");
    end else begin
      $display("integer_matrix_multiply verification failed");
    end
    $finish;
  end

  initial begin
    int unsigned gap;
    wait (rst_ni === 1'b1);
    forever begin
      gap = draw_gap();
      if (gap != 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      board.check_result(product_value_o, column_index_o, row_last_o);
    end
  end

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("timeout after %0d cycles", CycleLimit);
    $display("integer_matrix_multiply verification failed");
    $finish;
  end

endmodule
